// ----- hdl/gopd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the glyph outline path decoder.
// No dependencies; every other file refers to it by scoped names.
package gopd_pkg;

  localparam int unsigned MAX_POLYGON_BYTES = 65536;
  localparam int unsigned HEADER_WORDS      = 4;
  localparam int unsigned POINTS_W          = 16;
  localparam int unsigned JOB_FIFO_DEPTH    = 8;
  localparam int unsigned CFG_ADDR_W        = 3;

  localparam logic [15:0] REC_TYPE_LINE   = 16'd1;
  localparam logic [15:0] REC_TYPE_SPLINE = 16'd2;

  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_TYPE,
    PH_START_X,
    PH_START_Y,
    PH_RECORD,
    PH_PT_X,
    PH_PT_Y
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_SPLINE,
    KIND_SKIP
  } kind_e;

  typedef enum logic [1:0] {
    CMD_CLOSE,
    CMD_MOVE,
    CMD_LINE,
    CMD_CURVE
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SCALE_X,
    REG_SHEAR_Y,
    REG_SHEAR_X,
    REG_SCALE_Y,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_NEGATE_Y
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] shear_y;
    logic signed [31:0] shear_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic               negate_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_x:  32'sd65536,
    shear_y:  32'sd0,
    shear_x:  32'sd0,
    scale_y:  32'sd65536,
    offset_x: 32'sd0,
    offset_y: 32'sd0,
    negate_y: 1'b1
  };

  // What a job emits: an optional main result, then an optional final close
  typedef struct packed {
    logic has_main;
    cmd_e cmd;
    logic has_fin;
    logic trunc;
  } job_meta_t;

  // Parser output: raw points, end point held as a doubled midpoint sum
  typedef struct packed {
    job_meta_t          meta;
    logic [31:0]        ctrl_x;
    logic [31:0]        ctrl_y;
    logic signed [32:0] end_sum_x;
    logic signed [32:0] end_sum_y;
  } raw_job_t;

  typedef struct packed {
    job_meta_t   meta;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
  } res_job_t;

endpackage

// ----- hdl/glyph_outline_path_decoder.sv -----
`timescale 1ns / 1ps
// Glyph outline path decoder: configuration registers, parser, transform, queue.
// Depends on gopd_pkg, gopd_parser, gopd_xform and gopd_out_fifo.
//
// Usage
//   Input stream: one 32-bit little-endian outline word per beat on s_axis_tdata_i,
//   s_axis_tlast_i marking the last word of the buffer. Output stream: path
//   commands, one per beat; m_axis_tlast_o closes the run of results caused by one
//   input word, m_axis_tuser_o carries the command and the end-of-glyph flags.
//   Configuration: write the affine matrix, offsets and the y-negate flag through
//   cfg_we_i / cfg_addr_i / cfg_wdata_i, only while the block is idle.
// Pipeline and throughput
//   An accepted word passes the parse register, the operand register and the
//   product register, then the result queue, before its first result shows.
//   One word is taken every cycle while s_axis_tready_o is high; words giving two
//   results (any command plus the final close of the buffer) hold the output for
//   two beats. The transform runs eight 33x32 multipliers in parallel in one stage.
// Reset and stall
//   Reset loads the identity matrix with y negation and returns the parser to the
//   polygon byte-count word; the queue is emptied. When the receiver stalls,
//   results collect in an eight-job queue; s_axis_tready_o drops once queued jobs
//   plus jobs in flight would fill it, so nothing is ever dropped.
module glyph_outline_path_decoder #(
  parameter int unsigned MAX_POLYGON_BYTES = gopd_pkg::MAX_POLYGON_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [31:0]                     s_axis_tdata_i,  // [31:0] word
  input  logic                            s_axis_tlast_i,  // final_word
  // path commands
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] point_x, [63:32] point_y, [95:64] end_x, [127:96] end_y
  output logic [127:0]                    m_axis_tdata_o,
  output logic                            m_axis_tlast_o,  // run_last
  // [1:0] command, [2] glyph_done, [3] truncated
  output logic [3:0]                      m_axis_tuser_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [gopd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]                     cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(gopd_pkg::JOB_FIFO_DEPTH + 1);

  gopd_pkg::cfg_t     cfg_q, cfg_d;
  logic               in_fire;
  logic               job_valid;
  gopd_pkg::raw_job_t job;
  logic [1:0]         stage_cnt;
  logic               res_valid;
  gopd_pkg::res_job_t res;
  logic [CNT_W-1:0]   fifo_count;
  logic [CNT_W:0]     committed;

  // Configuration registers: hold unless written; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gopd_pkg::cfg_reg_e'(cfg_addr_i))
        gopd_pkg::REG_SCALE_X:  cfg_d.scale_x  = cfg_wdata_i;
        gopd_pkg::REG_SHEAR_Y:  cfg_d.shear_y  = cfg_wdata_i;
        gopd_pkg::REG_SHEAR_X:  cfg_d.shear_x  = cfg_wdata_i;
        gopd_pkg::REG_SCALE_Y:  cfg_d.scale_y  = cfg_wdata_i;
        gopd_pkg::REG_OFFSET_X: cfg_d.offset_x = cfg_wdata_i;
        gopd_pkg::REG_OFFSET_Y: cfg_d.offset_y = cfg_wdata_i;
        gopd_pkg::REG_NEGATE_Y: cfg_d.negate_y = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gopd_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Every job in flight has a queue slot reserved, so the pipeline never stalls
  // and tready depends on registered state only.
  assign committed = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(job_valid)
                   + (CNT_W + 1)'(stage_cnt);
  assign s_axis_tready_o = committed < (CNT_W + 1)'(gopd_pkg::JOB_FIFO_DEPTH);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  gopd_parser #(
    .MAX_POLYGON_BYTES(MAX_POLYGON_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .word_i     (s_axis_tdata_i),
    .final_i    (s_axis_tlast_i),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  gopd_xform u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .cfg_i      (cfg_q),
    .stage_cnt_o(stage_cnt),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  gopd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_user_o (m_axis_tuser_o),
    .count_o    (fifo_count)
  );

`ifndef SYNTHESIS
  a_no_overcommit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed <= (CNT_W + 1)'(gopd_pkg::JOB_FIFO_DEPTH))
    else $error("result queue overcommitted");
  a_done_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |->
    (m_axis_tuser_o[1:0] == gopd_pkg::CMD_CLOSE && m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("glyph end beat is not a bare final close");
  a_trunc_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[3]) |-> m_axis_tuser_o[2])
    else $error("truncation flagged outside the final close");
`endif

endmodule

// ----- hdl/gopd_parser.sv -----
`timescale 1ns / 1ps
// Outline word parser: polygon/record state machine and the job register.
// Depends on gopd_pkg.
module gopd_parser #(
  parameter int unsigned MAX_POLYGON_BYTES = gopd_pkg::MAX_POLYGON_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [31:0]         word_i,
  input  logic                final_i,
  output logic                job_valid_o,
  output gopd_pkg::raw_job_t  job_o
);

  localparam int unsigned WORDS_W = $clog2(MAX_POLYGON_BYTES / 4 + 1);
  localparam logic [WORDS_W-1:0] MAX_WORDS = WORDS_W'(MAX_POLYGON_BYTES / 4);
  localparam logic [WORDS_W-1:0] HDR_WORDS = WORDS_W'(gopd_pkg::HEADER_WORDS);

  gopd_pkg::phase_e              phase_q, phase_d, step_phase;
  gopd_pkg::kind_e               kind_q, kind_d;
  logic [WORDS_W-1:0]            left_q, left_d, left_dec;
  logic [gopd_pkg::POINTS_W-1:0] pts_q, pts_d, pts_dec;
  logic                          first_q, first_d;
  logic [31:0]                   held_q, held_d;
  logic [31:0]                   prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [WORDS_W-1:0]            words_clamp, words;
  logic [15:0]                   rec_type;
  logic                          job_valid_q, job_valid_d;
  gopd_pkg::raw_job_t            job_q, job_d;

  assign rec_type    = word_i[15:0];
  assign left_dec    = left_q - WORDS_W'(1);
  assign pts_dec     = pts_q - gopd_pkg::POINTS_W'(1);
  assign words_clamp = (word_i > 32'(MAX_POLYGON_BYTES)) ? MAX_WORDS : word_i[WORDS_W+1:2];
  assign words       = (words_clamp < HDR_WORDS) ? HDR_WORDS : words_clamp;

  // Next state
  always_comb begin
    step_phase = phase_q;
    left_d     = left_q;
    kind_d     = kind_q;
    pts_d      = pts_q;
    first_d    = first_q;
    held_d     = held_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    case (phase_q)
      gopd_pkg::PH_COUNT: begin
        left_d     = words - HDR_WORDS;
        step_phase = gopd_pkg::PH_TYPE;
      end
      gopd_pkg::PH_TYPE: begin
        step_phase = gopd_pkg::PH_START_X;
      end
      gopd_pkg::PH_START_X: begin
        held_d     = word_i;
        step_phase = gopd_pkg::PH_START_Y;
      end
      gopd_pkg::PH_START_Y: begin
        step_phase = (left_q != '0) ? gopd_pkg::PH_RECORD : gopd_pkg::PH_COUNT;
      end
      gopd_pkg::PH_RECORD: begin
        left_d  = left_dec;
        kind_d  = (rec_type == gopd_pkg::REC_TYPE_LINE)   ? gopd_pkg::KIND_LINE :
                  (rec_type == gopd_pkg::REC_TYPE_SPLINE) ? gopd_pkg::KIND_SPLINE :
                                                            gopd_pkg::KIND_SKIP;
        pts_d   = word_i[31:16];
        first_d = 1'b1;
        step_phase = (word_i[31:16] != '0) ? gopd_pkg::PH_PT_X : gopd_pkg::PH_RECORD;
        if (left_dec == '0) step_phase = gopd_pkg::PH_COUNT;
      end
      gopd_pkg::PH_PT_X: begin
        left_d     = left_dec;
        held_d     = word_i;
        step_phase = (left_dec != '0) ? gopd_pkg::PH_PT_Y : gopd_pkg::PH_COUNT;
      end
      gopd_pkg::PH_PT_Y: begin
        left_d = left_dec;
        pts_d  = pts_dec;
        if (kind_q == gopd_pkg::KIND_SPLINE) begin
          first_d  = 1'b0;
          prev_x_d = held_q;
          prev_y_d = word_i;
        end
        step_phase = (pts_dec != '0) ? gopd_pkg::PH_PT_X : gopd_pkg::PH_RECORD;
        if (left_dec == '0) step_phase = gopd_pkg::PH_COUNT;
      end
      default: begin
        step_phase = gopd_pkg::PH_COUNT;
      end
    endcase
    phase_d = step_phase;
    // buffer end drops the parser back to its reset state
    if (final_i) begin
      phase_d  = gopd_pkg::PH_COUNT;
      left_d   = '0;
      kind_d   = gopd_pkg::KIND_LINE;
      pts_d    = '0;
      first_d  = 1'b1;
      held_d   = '0;
      prev_x_d = '0;
      prev_y_d = '0;
    end
  end

  // Job for this beat
  always_comb begin
    job_d.meta.has_main = 1'b0;
    job_d.meta.cmd      = gopd_pkg::CMD_CLOSE;
    job_d.meta.has_fin  = final_i;
    job_d.meta.trunc    = final_i && (step_phase != gopd_pkg::PH_COUNT);
    job_d.ctrl_x        = held_q;
    job_d.ctrl_y        = word_i;
    job_d.end_sum_x     = '0;
    job_d.end_sum_y     = '0;
    case (phase_q)
      gopd_pkg::PH_COUNT: begin
        job_d.meta.has_main = 1'b1;
      end
      gopd_pkg::PH_START_Y: begin
        job_d.meta.has_main = 1'b1;
        job_d.meta.cmd      = gopd_pkg::CMD_MOVE;
      end
      gopd_pkg::PH_PT_Y: begin
        if (kind_q == gopd_pkg::KIND_LINE) begin
          job_d.meta.has_main = 1'b1;
          job_d.meta.cmd      = gopd_pkg::CMD_LINE;
        end else if (kind_q == gopd_pkg::KIND_SPLINE && !first_q) begin
          job_d.meta.has_main = 1'b1;
          job_d.meta.cmd      = gopd_pkg::CMD_CURVE;
          job_d.ctrl_x        = prev_x_q;
          job_d.ctrl_y        = prev_y_q;
          // last point of the record: end on the point itself (sum of it twice)
          if (pts_dec != '0) begin
            job_d.end_sum_x = $signed({prev_x_q[31], prev_x_q}) + $signed({held_q[31], held_q});
            job_d.end_sum_y = $signed({prev_y_q[31], prev_y_q}) + $signed({word_i[31], word_i});
          end else begin
            job_d.end_sum_x = $signed({held_q[31], held_q}) + $signed({held_q[31], held_q});
            job_d.end_sum_y = $signed({word_i[31], word_i}) + $signed({word_i[31], word_i});
          end
        end
      end
      default: begin
      end
    endcase
    job_valid_d = in_fire_i && (job_d.meta.has_main || final_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gopd_pkg::PH_COUNT;
      left_q      <= '0;
      kind_q      <= gopd_pkg::KIND_LINE;
      pts_q       <= '0;
      first_q     <= 1'b1;
      held_q      <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        phase_q  <= phase_d;
        left_q   <= left_d;
        kind_q   <= kind_d;
        pts_q    <= pts_d;
        first_q  <= first_d;
        held_q   <= held_d;
        prev_x_q <= prev_x_d;
        prev_y_q <= prev_y_d;
      end
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

`ifndef SYNTHESIS
  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && final_i) |=> (phase_q == gopd_pkg::PH_COUNT && left_q == '0))
    else $error("parser not back at polygon start after buffer end");
  a_point_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == gopd_pkg::PH_PT_X || phase_q == gopd_pkg::PH_PT_Y) |->
    (left_q != '0 && pts_q != '0))
    else $error("point phase entered with no words or points left");
`endif

endmodule

// ----- hdl/gopd_xform.sv -----
`timescale 1ns / 1ps
// Affine transform pipeline: operand prep, product register, round and saturate.
// Depends on gopd_pkg.
module gopd_xform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  gopd_pkg::raw_job_t job_i,
  input  gopd_pkg::cfg_t     cfg_i,
  output logic [1:0]         stage_cnt_o,
  output logic               res_valid_o,
  output gopd_pkg::res_job_t res_o
);

  // sum of two 16.16 products plus offset, rounded half up, saturated
  function automatic logic [31:0] round_sat(input logic signed [64:0] p1,
                                            input logic signed [64:0] p2,
                                            input logic signed [31:0] off);
    logic signed [66:0] acc;
    logic [50:0]        r;
    acc = 67'(p1) + 67'(p2) + 67'($signed({off, 16'h8000}));
    r   = acc[66:16];
    if (r[50:31] == {20{r[50]}}) begin
      round_sat = r[31:0];
    end else begin
      round_sat = r[50] ? gopd_pkg::COORD_MIN : gopd_pkg::COORD_MAX;
    end
  endfunction

  // operand stage
  logic signed [32:0]  cx, cy_raw, cy, ex, ey_raw, ey;
  logic signed [32:0]  msum_x, msum_y;
  logic                op_valid_q;
  gopd_pkg::job_meta_t op_meta_q;
  logic signed [32:0]  cx_q, cy_q, ex_q, ey_q;

  // product stage
  logic                prod_valid_q;
  gopd_pkg::job_meta_t prod_meta_q;
  logic signed [64:0]  c_sx_q, c_hx_q, c_hy_q, c_sy_q;
  logic signed [64:0]  e_sx_q, e_hx_q, e_hy_q, e_sy_q;

  assign cx     = $signed({job_i.ctrl_x[31], job_i.ctrl_x});
  assign cy_raw = $signed({job_i.ctrl_y[31], job_i.ctrl_y});
  assign cy     = cfg_i.negate_y ? -cy_raw : cy_raw;
  // halve toward zero: add one to a negative sum before the shift
  assign msum_x = job_i.end_sum_x + $signed({32'd0, job_i.end_sum_x[32]});
  assign msum_y = job_i.end_sum_y + $signed({32'd0, job_i.end_sum_y[32]});
  assign ex     = $signed({msum_x[32], msum_x[32:1]});
  assign ey_raw = $signed({msum_y[32], msum_y[32:1]});
  assign ey     = cfg_i.negate_y ? -ey_raw : ey_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      op_valid_q   <= job_valid_i;
      prod_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_meta_q   <= job_i.meta;
    cx_q        <= cx;
    cy_q        <= cy;
    ex_q        <= ex;
    ey_q        <= ey;
    prod_meta_q <= op_meta_q;
    c_sx_q      <= cx_q * cfg_i.scale_x;
    c_hx_q      <= cy_q * cfg_i.shear_x;
    c_hy_q      <= cx_q * cfg_i.shear_y;
    c_sy_q      <= cy_q * cfg_i.scale_y;
    e_sx_q      <= ex_q * cfg_i.scale_x;
    e_hx_q      <= ey_q * cfg_i.shear_x;
    e_hy_q      <= ex_q * cfg_i.shear_y;
    e_sy_q      <= ey_q * cfg_i.scale_y;
  end

  always_comb begin
    res_o.meta    = prod_meta_q;
    res_o.point_x = '0;
    res_o.point_y = '0;
    res_o.end_x   = '0;
    res_o.end_y   = '0;
    if (prod_meta_q.cmd != gopd_pkg::CMD_CLOSE) begin
      res_o.point_x = round_sat(c_sx_q, c_hx_q, cfg_i.offset_x);
      res_o.point_y = round_sat(c_hy_q, c_sy_q, cfg_i.offset_y);
    end
    if (prod_meta_q.cmd == gopd_pkg::CMD_CURVE) begin
      res_o.end_x = round_sat(e_sx_q, e_hx_q, cfg_i.offset_x);
      res_o.end_y = round_sat(e_hy_q, e_sy_q, cfg_i.offset_y);
    end
  end

  assign res_valid_o = prod_valid_q;
  assign stage_cnt_o = {1'b0, op_valid_q} + {1'b0, prod_valid_q};

endmodule

// ----- hdl/gopd_out_fifo.sv -----
`timescale 1ns / 1ps
// Result job queue and beat sequencer for the output stream.
// Depends on gopd_pkg.
module gopd_out_fifo (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           push_i,
  input  gopd_pkg::res_job_t                             push_data_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output logic [127:0]                                   out_data_o,
  output logic                                           out_last_o,
  output logic [3:0]                                     out_user_o,
  output logic [$clog2(gopd_pkg::JOB_FIFO_DEPTH+1)-1:0]  count_o
);

  localparam int unsigned DEPTH = gopd_pkg::JOB_FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gopd_pkg::res_job_t mem_q [DEPTH];
  gopd_pkg::res_job_t head;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               second_q, second_d;
  logic               emit_main, last, fire, pop;

  assign head      = mem_q[rd_ptr_q];
  assign emit_main = head.meta.has_main && !second_q;
  assign last      = !(emit_main && head.meta.has_fin);
  assign fire      = out_valid_o && out_ready_i;
  assign pop       = fire && last;

  always_comb begin
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop);
    second_d = second_q;
    if (pop) begin
      second_d = 1'b0;
    end else if (fire) begin
      second_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      second_q <= 1'b0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      count_q  <= count_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    if (emit_main) begin
      out_data_o = {head.end_y, head.end_x, head.point_y, head.point_x};
      out_user_o = {1'b0, 1'b0, head.meta.cmd};
    end else begin
      out_data_o = '0;
      out_user_o = {head.meta.trunc, 1'b1, gopd_pkg::CMD_CLOSE};
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_last_o  = last;
  assign count_o     = count_q;

endmodule

// ----- verif/tb_glyph_outline_path_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for glyph_outline_path_decoder: drives outline words,
// predicts the path commands in a small tracker class and checks every result beat.
// Depends on gopd_pkg and the decoder RTL only.
module tb_glyph_outline_path_decoder;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_WORDS   = 160;
  localparam int unsigned DRAIN_CYCLES  = 8;      // lets the pipeline run dry after the last due command
  localparam logic [31:0] POLY_TYPE     = 32'd24;

  // One expected path command, fields as they appear on the result stream
  typedef struct packed {
    gopd_pkg::cmd_e cmd;
    logic [31:0]    point_x;
    logic [31:0]    point_y;
    logic [31:0]    end_x;
    logic [31:0]    end_y;
    logic           run_last;
    logic           glyph_done;
    logic           truncated;
  } path_cmd_t;

  // Mirrors the decoder: parser state, matrix copy and the queue of commands still due
  class path_command_tracker;
    path_cmd_t        due_cmds[$];
    int unsigned      errors;
    int unsigned      checked;

    longint           scale_x, shear_y, shear_x, scale_y, offset_x, offset_y;
    bit               negate_y;

    gopd_pkg::phase_e phase;
    gopd_pkg::kind_e  kind;
    int unsigned      words_left;
    int unsigned      points_left;
    bit               first_pt;
    logic [31:0]      held_x, prev_x, prev_y;

    function new();
      scale_x  = longint'(gopd_pkg::CFG_RESET.scale_x);
      shear_y  = longint'(gopd_pkg::CFG_RESET.shear_y);
      shear_x  = longint'(gopd_pkg::CFG_RESET.shear_x);
      scale_y  = longint'(gopd_pkg::CFG_RESET.scale_y);
      offset_x = longint'(gopd_pkg::CFG_RESET.offset_x);
      offset_y = longint'(gopd_pkg::CFG_RESET.offset_y);
      negate_y = gopd_pkg::CFG_RESET.negate_y;
      errors   = 0;
      checked  = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase       = gopd_pkg::PH_COUNT;
      kind        = gopd_pkg::KIND_LINE;
      words_left  = 0;
      points_left = 0;
      first_pt    = 1'b1;
      held_x      = '0;
      prev_x      = '0;
      prev_y      = '0;
    endfunction

    function void set_reg(gopd_pkg::cfg_reg_e idx, logic [31:0] v);
      case (idx)
        gopd_pkg::REG_SCALE_X:  scale_x  = longint'($signed(v));
        gopd_pkg::REG_SHEAR_Y:  shear_y  = longint'($signed(v));
        gopd_pkg::REG_SHEAR_X:  shear_x  = longint'($signed(v));
        gopd_pkg::REG_SCALE_Y:  scale_y  = longint'($signed(v));
        gopd_pkg::REG_OFFSET_X: offset_x = longint'($signed(v));
        gopd_pkg::REG_OFFSET_Y: offset_y = longint'($signed(v));
        gopd_pkg::REG_NEGATE_Y: negate_y = v[0];
        default: ;
      endcase
    endfunction

    // a*x + b*y + off in 16.16: fractions of both products summed, rounded half up,
    // then saturated to 32 bits
    function logic [31:0] affine_16_16(longint x, longint y, longint a, longint b,
                                       longint off);
      longint p1, p2, frac, r;
      p1   = x * a;
      p2   = y * b;
      frac = (p1 & 64'hFFFF) + (p2 & 64'hFFFF) + 32768;
      r    = (p1 >>> 16) + (p2 >>> 16) + off + (frac >>> 16);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void map_point(longint x, longint y, output logic [31:0] ox,
                            output logic [31:0] oy);
      if (negate_y) y = -y;
      ox = affine_16_16(x, y, scale_x, shear_x, offset_x);
      oy = affine_16_16(x, y, shear_y, scale_y, offset_y);
    endfunction

    function void push_cmd(gopd_pkg::cmd_e c, logic [31:0] px, logic [31:0] py,
                           logic [31:0] ex, logic [31:0] ey, bit last, bit done,
                           bit trunc);
      path_cmd_t e;
      e.cmd        = c;
      e.point_x    = px;
      e.point_y    = py;
      e.end_x      = ex;
      e.end_y      = ey;
      e.run_last   = last;
      e.glyph_done = done;
      e.truncated  = trunc;
      due_cmds.push_back(e);
    endfunction

    // Advance the parser by one accepted outline word and queue what it causes;
    // the main command is the last of its run unless the buffer ends here
    function void note_word(logic [31:0] w, bit fin);
      int unsigned nbytes, nwords;
      longint      cx, cy, bx, by, mx, my;
      logic [31:0] px, py, ex, ey;
      case (phase)
        gopd_pkg::PH_COUNT: begin
          nbytes = (w > gopd_pkg::MAX_POLYGON_BYTES) ? gopd_pkg::MAX_POLYGON_BYTES : w;
          nwords = nbytes >> 2;
          if (nwords < gopd_pkg::HEADER_WORDS) nwords = gopd_pkg::HEADER_WORDS;
          words_left = nwords - gopd_pkg::HEADER_WORDS;
          push_cmd(gopd_pkg::CMD_CLOSE, '0, '0, '0, '0, !fin, 1'b0, 1'b0);
          phase = gopd_pkg::PH_TYPE;
        end
        gopd_pkg::PH_TYPE: phase = gopd_pkg::PH_START_X;
        gopd_pkg::PH_START_X: begin
          held_x = w;
          phase  = gopd_pkg::PH_START_Y;
        end
        gopd_pkg::PH_START_Y: begin
          map_point(longint'($signed(held_x)), longint'($signed(w)), px, py);
          push_cmd(gopd_pkg::CMD_MOVE, px, py, '0, '0, !fin, 1'b0, 1'b0);
          if (words_left != 0) phase = gopd_pkg::PH_RECORD;
          else phase = gopd_pkg::PH_COUNT;
        end
        gopd_pkg::PH_RECORD: begin
          words_left--;
          if (w[15:0] == gopd_pkg::REC_TYPE_LINE) kind = gopd_pkg::KIND_LINE;
          else if (w[15:0] == gopd_pkg::REC_TYPE_SPLINE) kind = gopd_pkg::KIND_SPLINE;
          else kind = gopd_pkg::KIND_SKIP;
          points_left = w[31:16];
          first_pt    = 1'b1;
          if (points_left != 0) phase = gopd_pkg::PH_PT_X;
          else phase = gopd_pkg::PH_RECORD;
          if (words_left == 0) phase = gopd_pkg::PH_COUNT;
        end
        gopd_pkg::PH_PT_X: begin
          words_left--;
          held_x = w;
          if (words_left != 0) phase = gopd_pkg::PH_PT_Y;
          else phase = gopd_pkg::PH_COUNT;
        end
        default: begin
          cx = longint'($signed(held_x));
          cy = longint'($signed(w));
          words_left--;
          points_left--;
          if (kind == gopd_pkg::KIND_LINE) begin
            map_point(cx, cy, px, py);
            push_cmd(gopd_pkg::CMD_LINE, px, py, '0, '0, !fin, 1'b0, 1'b0);
          end else if (kind == gopd_pkg::KIND_SPLINE) begin
            if (!first_pt) begin
              // control is the previous point; end is the truncated midpoint,
              // or the point itself on the last point of the record
              bx = longint'($signed(prev_x));
              by = longint'($signed(prev_y));
              mx = cx;
              my = cy;
              if (points_left != 0) begin
                mx = (bx + cx) / 2;
                my = (by + cy) / 2;
              end
              map_point(bx, by, px, py);
              map_point(mx, my, ex, ey);
              push_cmd(gopd_pkg::CMD_CURVE, px, py, ex, ey, !fin, 1'b0, 1'b0);
            end
            first_pt = 1'b0;
            prev_x   = held_x;
            prev_y   = w;
          end
          if (points_left != 0) phase = gopd_pkg::PH_PT_X;
          else phase = gopd_pkg::PH_RECORD;
          if (words_left == 0) phase = gopd_pkg::PH_COUNT;
        end
      endcase
      if (fin) begin
        push_cmd(gopd_pkg::CMD_CLOSE, '0, '0, '0, '0, 1'b1, 1'b1,
                 phase != gopd_pkg::PH_COUNT);
        clear_parser();
      end
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_command(logic [127:0] data, logic last, logic [3:0] user);
      path_cmd_t e;
      if (due_cmds.size() == 0) begin
        $error("unexpected path command beat: command %0d", user[1:0]);
        errors++;
        return;
      end
      e = due_cmds.pop_front();
      checked++;
      compare("command",    32'(e.cmd),        32'(user[1:0]));
      compare("point_x",    e.point_x,         data[31:0]);
      compare("point_y",    e.point_y,         data[63:32]);
      compare("end_x",      e.end_x,           data[95:64]);
      compare("end_y",      e.end_y,           data[127:96]);
      compare("run_last",   32'(e.run_last),   32'(last));
      compare("glyph_done", 32'(e.glyph_done), 32'(user[2]));
      compare("truncated",  32'(e.truncated),  32'(user[3]));
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_n     = 1'b0;
  logic                            s_valid   = 1'b0;
  logic [31:0]                     s_data    = '0;
  logic                            s_last    = 1'b0;
  logic                            m_ready   = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [gopd_pkg::CFG_ADDR_W-1:0] cfg_addr  = gopd_pkg::REG_SCALE_X;
  logic [31:0]                     cfg_wdata = '0;

  logic                            s_axis_tready_o;
  logic                            m_axis_tvalid_o;
  logic [127:0]                    m_axis_tdata_o;   // point_x, point_y, end_x, end_y
  logic                            m_axis_tlast_o;   // run_last
  logic [3:0]                      m_axis_tuser_o;   // command[1:0], glyph_done, truncated

  path_command_tracker   sb = new();
  logic [31:0]           outline_words[$];
  bit                    idle_on      = 1'b0;
  int unsigned           stall_left   = 0;
  int unsigned           words_sent   = 0;
  int unsigned           settings_run = 0;
  int unsigned           cycle_count  = 0;

  glyph_outline_path_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: give up well beyond the slowest legal run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: check the beat taken at this edge, then pick the next ready level.
  // Stalls come in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_ready)
      sb.check_command(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    if (stall_left != 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_ready    <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Offer one word and hold it until the decoder takes it; sometimes pause first
  task automatic send_word(logic [31:0] w, bit fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= w;
    s_last  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_word(w, fin);
    words_sent++;
  endtask

  task automatic send_outline();
    for (int i = 0; i < outline_words.size(); i++)
      send_word(outline_words[i], i == outline_words.size() - 1);
  endtask

  // Drop valid, wait for every due command, then let the pipeline run dry
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.due_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(gopd_pkg::cfg_reg_e idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic write_matrix(logic [31:0] sx, logic [31:0] shy, logic [31:0] shx,
                              logic [31:0] sy, logic [31:0] ox, logic [31:0] oy,
                              bit neg);
    write_reg(gopd_pkg::REG_SCALE_X, sx);
    write_reg(gopd_pkg::REG_SHEAR_Y, shy);
    write_reg(gopd_pkg::REG_SHEAR_X, shx);
    write_reg(gopd_pkg::REG_SCALE_Y, sy);
    write_reg(gopd_pkg::REG_OFFSET_X, ox);
    write_reg(gopd_pkg::REG_OFFSET_Y, oy);
    write_reg(gopd_pkg::REG_NEGATE_Y, {31'd0, neg});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly modest coordinates, with the 32-bit extremes and raw noise mixed in
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  // Matrix term within about +-4.0
  function automatic logic [31:0] pick_coef();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // Append one polygon: header, a few records, byte count patched in at the end
  function automatic void add_polygon(bit bad_count);
    int unsigned head, nrec, npts, sel, nbytes;
    logic [15:0] rtype;
    head = outline_words.size();
    outline_words.push_back(32'd0);
    outline_words.push_back($urandom_range(0, 1) ? POLY_TYPE : $urandom());
    outline_words.push_back(pick_coord());
    outline_words.push_back(pick_coord());
    nrec = $urandom_range(0, 4);
    repeat (nrec) begin
      sel  = $urandom_range(0, 9);
      npts = $urandom_range(1, 5);
      if (sel < 4) rtype = gopd_pkg::REC_TYPE_LINE;
      else if (sel < 8) rtype = gopd_pkg::REC_TYPE_SPLINE;
      else rtype = 16'($urandom_range(0, 16'hFFFF));
      if (sel == 9) npts = 0;
      outline_words.push_back({npts[15:0], rtype});
      repeat (2 * npts) outline_words.push_back(pick_coord());
    end
    nbytes = (outline_words.size() - head) * 4 + $urandom_range(0, 3);
    if (bad_count) begin
      case ($urandom_range(0, 2))
        0:       nbytes = $urandom_range(0, 63);
        1:       nbytes = $urandom();
        default: nbytes = $urandom_range(0, nbytes + 64);
      endcase
    end
    outline_words[head] = nbytes;
  endfunction

  // One glyph buffer: mostly well-formed, some cut short, some with wrong counts,
  // some plain noise
  function automatic void build_glyph();
    int unsigned mode, keep;
    outline_words.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 12)) outline_words.push_back($urandom());
    end else begin
      repeat ($urandom_range(1, 3)) add_polygon(mode == 1);
      if (mode <= 2 && outline_words.size() > 1) begin
        keep = $urandom_range(1, outline_words.size() - 1);
        outline_words = outline_words[0:keep-1];
      end
    end
  endfunction

  // Directed outline under the reset matrix: saturating line point, a three-point
  // spline with a negative odd midpoint, a header-only polygon with a short count,
  // an oversized count, an unknown record, an empty spline, and a buffer that ends
  // mid-polygon. A second buffer ends on its byte-count word.
  task automatic run_directed();
    outline_words = '{32'd56, POLY_TYPE, 32'h0001_0000, 32'h0002_8000,
                      32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0003_0002, 32'hFFFD_0000, 32'h0000_0005,
                      32'hFFFF_FFFE, 32'hFFFF_FFFB, 32'h0000_0001, 32'h0000_0007,
                      32'd4, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000,
                      32'hFFFF_FFFF, POLY_TYPE, 32'h1234_5678, 32'hFEDC_BA98,
                      32'h0001_0009, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0002};
    send_outline();
    outline_words = '{32'd16};
    send_outline();
    settle();
  endtask

  task automatic apply_setting(int unsigned ph);
    case (ph)
      1: write_matrix(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                      $urandom(), $urandom(), $urandom_range(0, 1));
      2: write_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      3: write_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 1'b1);
      4: write_matrix($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom_range(0, 1));
      default: write_matrix(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                            pick_coef(), pick_coef(), 1'b0);
    endcase
  endtask

  initial begin
    int unsigned phase_start;
    bit          paused;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    run_directed();

    paused = 1'b0;
    for (int unsigned ph = 1; ph <= RANDOM_PHASES; ph++) begin
      apply_setting(ph);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        // hold idling off for the whole last phase, and now and then elsewhere
        idle_on = (ph != RANDOM_PHASES) && ($urandom_range(0, 3) != 0);
        build_glyph();
        send_outline();
        // hold the sender until the result stream has fully caught up, once
        if (ph == 2 && !paused && words_sent - phase_start >= PHASE_WORDS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    $display("Decoded %0d outline words into %0d checked path commands",
             words_sent, sb.checked);
    $display("Covered directed outlines plus random glyphs under %0d matrix settings",
             settings_run);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
